>>> hw/rtl/acbt_pkg.sv
// Shared types, constants and helpers of the async copy barrier tracker.
package acbt_pkg;

  // Number of barrier records held in the table.
  localparam int unsigned Entries = 64;
  // Width of the live record counter; its range of 0 to 127 covers every count up to Entries.
  localparam int unsigned LiveW = 7;

  // Operation codes carried by the func field.
  typedef enum logic [2:0] {
    FUNC_CREATE  = 3'd0,
    FUNC_NATIVE  = 3'd1,
    FUNC_ADD     = 3'd2,
    FUNC_FAULT   = 3'd3,
    FUNC_CONSUME = 3'd4,
    FUNC_INVAL   = 3'd5,
    FUNC_QUERY   = 3'd6
  } func_e;

  // State of a key as reported in the result word.
  typedef enum logic [2:0] {
    ST_NATIVE_PENDING = 3'd0,
    ST_SHADOW_PENDING = 3'd1,
    ST_READY          = 3'd2,
    ST_CONSUMED       = 3'd3,
    ST_ABSENT         = 3'd4
  } status_e;

  // Kind of table write requested by the operation logic.
  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_CREATE = 2'd1,
    WR_UPDATE = 2'd2,
    WR_FREE   = 2'd3
  } wr_op_e;

  // Result of the associative lookup for the current key.
  typedef struct packed {
    logic        hit;
    logic        full;
    logic        native;
    logic        faulted;
    logic        consumed;
    logic [31:0] expected;
    logic [31:0] arrived;
  } lookup_t;

  // Write command from the operation logic to the table.
  typedef struct packed {
    wr_op_e      op;
    logic        native;
    logic        faulted;
    logic        consumed;
    logic [31:0] arrived;
  } wr_t;

  // State of a key from its record flags and byte counts.
  function automatic status_e status_of(input logic        present,
                                        input logic        faulted,
                                        input logic        consumed,
                                        input logic        native,
                                        input logic [31:0] arrived,
                                        input logic [31:0] expected);
    status_e st;
    if (!present || faulted) begin
      st = ST_ABSENT;
    end else if (consumed) begin
      st = ST_CONSUMED;
    end else if (native) begin
      st = (arrived == expected) ? ST_READY : ST_SHADOW_PENDING;
    end else begin
      st = ST_NATIVE_PENDING;
    end
    return st;
  endfunction

endpackage

>>> hw/rtl/async_copy_barrier_tracker_top.sv
// Top level of the async copy barrier tracker: input register, operation logic, result register.
// The tracker takes one word per clock cycle while the result side does not stall, and returns
// exactly one result word for each, in order. A word is held in the input register, where the key
// is compared against all records at once and the operation is applied, and its result is loaded
// into the output register once that register is free, from where it is offered. The throughput
// of one word per cycle is set by the single pass of parallel key compare, record select and one
// 32-bit add and compare; a stall on the result side holds the result register and then the input
// register. No clearing pass is needed after reset: valid bits are cleared at once.
module async_copy_barrier_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] cluster_id_i,
  input  logic [3:0]  target_rank_i,
  input  logic [31:0] barrier_addr_i,
  input  logic [31:0] phase_number_i,
  input  logic [31:0] byte_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  entry_status_o,
  output logic [6:0]  live_count_o,
  output logic        table_full_o
);
  import acbt_pkg::*;

  // Input register.
  logic        s1_valid_q;
  func_e       s1_func_q;
  logic [15:0] s1_cluster_q;
  logic [3:0]  s1_rank_q;
  logic [31:0] s1_barrier_q;
  logic [31:0] s1_phase_q;
  logic [31:0] s1_bytes_q;

  // Result register.
  logic        out_valid_q;
  logic        acc_q;
  status_e     status_q;
  logic        full_q;

  logic [LiveW-1:0] live_q;
  logic [LiveW-1:0] live_d;

  logic    in_accept;
  logic    fire;
  lookup_t lookup;
  wr_t     wr;
  logic    acc_d;
  logic    full_d;
  status_e status_d;
  status_e status_cur;
  logic    present_n;
  logic    native_n;
  logic    faulted_n;
  logic    consumed_n;
  logic [31:0] arrived_n;
  logic [31:0] expected_n;
  logic [31:0] remaining;
  logic [31:0] arrived_sum;
  logic        key_live;

  // Handshake: a word in the input register moves on when the result register is free.
  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q    <= func_e'(func_i);
      s1_cluster_q <= cluster_id_i;
      s1_rank_q    <= target_rank_i;
      s1_barrier_q <= barrier_addr_i;
      s1_phase_q   <= phase_number_i;
      s1_bytes_q   <= byte_count_i;
    end
  end

  acbt_table u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cluster_id_i   (s1_cluster_q),
    .target_rank_i  (s1_rank_q),
    .barrier_addr_i (s1_barrier_q),
    .phase_number_i (s1_phase_q),
    .byte_count_i   (s1_bytes_q),
    .wr_i           (wr),
    .lookup_o       (lookup)
  );

  assign remaining   = lookup.expected - lookup.arrived;
  assign arrived_sum = lookup.arrived + s1_bytes_q;
  assign key_live    = lookup.hit && !lookup.faulted && !lookup.consumed;
  assign status_cur  = status_of(lookup.hit, lookup.faulted, lookup.consumed, lookup.native,
                                 lookup.arrived, lookup.expected);

  // Operation logic: decide acceptance, the record's new state and the counter change.
  always_comb begin
    acc_d      = 1'b0;
    full_d     = 1'b0;
    live_d     = live_q;
    present_n  = lookup.hit;
    native_n   = lookup.native;
    faulted_n  = lookup.faulted;
    consumed_n = lookup.consumed;
    arrived_n  = lookup.arrived;
    expected_n = lookup.expected;
    wr         = '0;
    wr.op      = WR_NONE;
    case (s1_func_q)
      FUNC_CREATE: begin
        if (s1_barrier_q != '0 && s1_bytes_q != '0 && !lookup.hit) begin
          if (lookup.full) begin
            full_d = 1'b1;
          end else begin
            acc_d      = 1'b1;
            wr.op      = WR_CREATE;
            present_n  = 1'b1;
            native_n   = 1'b0;
            faulted_n  = 1'b0;
            consumed_n = 1'b0;
            arrived_n  = '0;
            expected_n = s1_bytes_q;
            live_d     = live_q + LiveW'(1);
          end
        end
      end
      FUNC_NATIVE: begin
        if (key_live && !lookup.native) begin
          acc_d    = 1'b1;
          wr.op    = WR_UPDATE;
          native_n = 1'b1;
        end
      end
      FUNC_ADD: begin
        if (key_live && s1_bytes_q != '0 && s1_bytes_q <= remaining) begin
          acc_d     = 1'b1;
          wr.op     = WR_UPDATE;
          arrived_n = arrived_sum;
        end
      end
      FUNC_FAULT: begin
        if (key_live) begin
          acc_d     = 1'b1;
          wr.op     = WR_UPDATE;
          faulted_n = 1'b1;
          live_d    = live_q - LiveW'(1);
        end
      end
      FUNC_CONSUME: begin
        if (status_cur == ST_READY) begin
          acc_d      = 1'b1;
          wr.op      = WR_UPDATE;
          consumed_n = 1'b1;
          live_d     = live_q - LiveW'(1);
        end
      end
      FUNC_INVAL: begin
        if (lookup.hit && (lookup.consumed || lookup.faulted)) begin
          acc_d     = 1'b1;
          wr.op     = WR_FREE;
          present_n = 1'b0;
        end
      end
      FUNC_QUERY: begin
        acc_d = lookup.hit;
      end
      default: begin
        acc_d = 1'b0;
      end
    endcase
    wr.native   = native_n;
    wr.faulted  = faulted_n;
    wr.consumed = consumed_n;
    wr.arrived  = arrived_n;
    // Nothing is committed unless the word moves into the result register.
    if (!fire) begin
      wr.op  = WR_NONE;
      live_d = live_q;
    end
  end

  assign status_d = status_of(present_n, faulted_n, consumed_n, native_n, arrived_n,
                              expected_n);

  // Live record counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= live_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload; the live count is read from the counter itself.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q    <= acc_d;
      status_q <= status_d;
      full_q   <= full_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign entry_status_o = status_q;
  assign live_count_o   = live_q;
  assign table_full_o   = full_q;

  // A refused create for lack of space is never reported as accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && table_full_o) |-> !accepted_o)
    else $error("acbt: table full reported on an accepted word");

  // The counter never exceeds the number of records.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (32'(live_q) <= 32'(Entries)))
    else $error("acbt: live count above table size");

  // A word that moves on always shows up as a result at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> out_valid_q)
    else $error("acbt: result lost after processing");

  // The counter only moves when a word is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !fire |=> $stable(live_q))
    else $error("acbt: live count changed without a word");

endmodule

>>> hw/rtl/acbt_table.sv
// Fully associative record table with parallel key compare and free-entry search.
module acbt_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     cluster_id_i,
  input  logic [3:0]      target_rank_i,
  input  logic [31:0]     barrier_addr_i,
  input  logic [31:0]     phase_number_i,
  input  logic [31:0]     byte_count_i,
  input  acbt_pkg::wr_t   wr_i,
  output acbt_pkg::lookup_t lookup_o
);
  import acbt_pkg::*;

  logic [Entries-1:0] valid_q;
  logic [15:0]        cluster_q  [Entries];
  logic [3:0]         rank_q     [Entries];
  logic [31:0]        barrier_q  [Entries];
  logic [31:0]        phase_q    [Entries];
  logic [31:0]        expected_q [Entries];
  logic [31:0]        arrived_q  [Entries];
  logic [Entries-1:0] native_q;
  logic [Entries-1:0] faulted_q;
  logic [Entries-1:0] consumed_q;

  logic [Entries-1:0] hit;
  logic [Entries-1:0] free_oh;

  // Compare the key against every valid record at once.
  always_comb begin
    for (int k = 0; k < Entries; k++) begin
      hit[k] = valid_q[k] && (cluster_q[k] == cluster_id_i) &&
               (rank_q[k] == target_rank_i) && (barrier_q[k] == barrier_addr_i) &&
               (phase_q[k] == phase_number_i);
    end
  end

  // The lowest clear valid bit marks the entry that a create fills.
  assign free_oh = ~valid_q & (valid_q + Entries'(1));

  // Gather the fields of the matching record; keys are unique among valid records.
  always_comb begin
    lookup_o          = '0;
    lookup_o.hit      = |hit;
    lookup_o.full     = &valid_q;
    for (int k = 0; k < Entries; k++) begin
      if (hit[k]) begin
        lookup_o.native   = lookup_o.native   | native_q[k];
        lookup_o.faulted  = lookup_o.faulted  | faulted_q[k];
        lookup_o.consumed = lookup_o.consumed | consumed_q[k];
        lookup_o.expected = lookup_o.expected | expected_q[k];
        lookup_o.arrived  = lookup_o.arrived  | arrived_q[k];
      end
    end
  end

  // Valid bits: set on create, cleared on invalidate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < Entries; k++) begin
        if (wr_i.op == WR_CREATE && free_oh[k]) begin
          valid_q[k] <= 1'b1;
        end else if (wr_i.op == WR_FREE && hit[k]) begin
          valid_q[k] <= 1'b0;
        end
      end
    end
  end

  // Record contents: filled on create, updated in place by the other operations.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Entries; k++) begin
      if (wr_i.op == WR_CREATE && free_oh[k]) begin
        cluster_q[k]  <= cluster_id_i;
        rank_q[k]     <= target_rank_i;
        barrier_q[k]  <= barrier_addr_i;
        phase_q[k]    <= phase_number_i;
        expected_q[k] <= byte_count_i;
        arrived_q[k]  <= '0;
        native_q[k]   <= 1'b0;
        faulted_q[k]  <= 1'b0;
        consumed_q[k] <= 1'b0;
      end else if (wr_i.op == WR_UPDATE && hit[k]) begin
        arrived_q[k]  <= wr_i.arrived;
        native_q[k]   <= wr_i.native;
        faulted_q[k]  <= wr_i.faulted;
        consumed_q[k] <= wr_i.consumed;
      end
    end
  end

  // A key never matches more than one record.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit))
    else $error("acbt_table: key matches several records");

  // A create is only issued when a free entry exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (wr_i.op == WR_CREATE) |-> (!lookup_o.full && !lookup_o.hit))
    else $error("acbt_table: create issued with no free entry or a duplicate key");

  // A create fills exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (wr_i.op == WR_CREATE) |-> $onehot(free_oh))
    else $error("acbt_table: create does not select exactly one entry");

endmodule
